// File: rtl/dpq_pkg.sv
// Shared types, field widths and operation/status codes for the
// double-ended priority queue. No dependencies.
`default_nettype none

package dpq_pkg;

  localparam int KEY_W     = 16;
  localparam int PAY_W     = 8;
  localparam int OP_W      = 3;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 5;

  // stream packing: in tdata = key, payload; out tdata = key, payload, count
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - KEY_W - PAY_W - CNT_OUT_W;

  localparam int DEFAULT_CAPACITY = 16;

  localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE_MAX = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_MIN = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK_MAX   = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_MIN   = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } dpq_entry_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic       insert;   // open a slot at the sorted position, load new entry
    logic       shift;    // every cell takes its right neighbor (drop head)
    dpq_entry_t entry;    // entry to insert
  } dpq_cmd_t;

endpackage

`default_nettype wire

// File: rtl/double_ended_priority_queue.sv
// Double-ended priority queue over a chain of sorted cells, max at slot 0.
// Insert, remove max, peek max, empty/full and unknown requests give their
// result in the cycle after acceptance; one such item per cycle unless the
// output stalls. Remove min and peek min walk the tail entry down the readout
// chain to slot 0, one cell a cycle. Synchronous active-high reset empties
// the queue and the output register; slot contents are not cleared.
// Depends on dpq_pkg and dpq_cell.
`default_nettype none

module double_ended_priority_queue #(
  parameter int CAPACITY = dpq_pkg::DEFAULT_CAPACITY
) (
  input  wire                            clk,
  input  wire                            rst,
  // s_tdata: key [15:0], payload [23:16]
  input  wire  [dpq_pkg::IN_DATA_W-1:0]  s_tdata,
  // s_tuser: operation [2:0]
  input  wire  [dpq_pkg::OP_W-1:0]       s_tuser,
  input  wire                            s_tvalid,
  output logic                           s_tready,
  // m_tdata: out_key [15:0], out_payload [23:16], entry_count [28:24], zero pad
  output logic [dpq_pkg::OUT_DATA_W-1:0] m_tdata,
  // m_tuser: status [1:0]
  output logic [dpq_pkg::STATUS_W-1:0]   m_tuser,
  output logic                           m_tvalid,
  input  wire                            m_tready
);
  import dpq_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int WAIT_W = $clog2(CAPACITY);

  localparam logic S_IDLE    = 1'b0;
  localparam logic S_COLLECT = 1'b1;

  logic              state;
  logic              state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [WAIT_W-1:0] wait_cnt;
  logic              min_remove;

  logic [STATUS_W-1:0] out_status;
  logic [KEY_W-1:0]    out_key;
  logic [PAY_W-1:0]    out_payload;
  logic [CNT_W-1:0]    out_count;

  logic [OP_W-1:0]  op;
  logic             s_fire;
  logic             out_free;
  logic             empty;
  logic             full;
  logic             load_out;
  logic             start_collect;
  logic             collect_done;
  dpq_cmd_t         cmd;
  dpq_entry_t       res_entry;
  logic [STATUS_W-1:0] res_status;

  dpq_entry_t cell_q     [CAPACITY];
  dpq_entry_t collect_q  [CAPACITY];
  logic       cell_gt    [CAPACITY];

  assign op       = s_tuser;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign s_fire   = s_tvalid && s_tready;
  assign empty    = count == '0;
  assign full     = count == CNT_W'(CAPACITY);

  assign collect_done = (state == S_COLLECT) && (wait_cnt == WAIT_W'(CAPACITY - 1))
                        && out_free;

  // decode the request: cell command, result and new count
  always_comb begin
    cmd.insert        = 1'b0;
    cmd.shift         = 1'b0;
    cmd.entry.key     = s_tdata[KEY_W-1:0];
    cmd.entry.payload = s_tdata[KEY_W+PAY_W-1:KEY_W];
    res_status        = STAT_OK;
    res_entry         = '0;
    count_next        = count;
    load_out          = 1'b0;
    start_collect     = 1'b0;
    if (s_fire) begin
      load_out = 1'b1;
      case (op)
        OP_INSERT: begin
          if (full) begin
            res_status = STAT_FULL;
          end else begin
            cmd.insert = 1'b1;
            count_next = count + 1'b1;
          end
        end
        OP_REMOVE_MAX: begin
          if (empty) begin
            res_status = STAT_EMPTY;
          end else begin
            res_entry  = cell_q[0];
            cmd.shift  = 1'b1;
            count_next = count - 1'b1;
          end
        end
        OP_PEEK_MAX: begin
          if (empty) begin
            res_status = STAT_EMPTY;
          end else begin
            res_entry = cell_q[0];
          end
        end
        OP_REMOVE_MIN, OP_PEEK_MIN: begin
          if (empty) begin
            res_status = STAT_EMPTY;
          end else begin
            load_out      = 1'b0;
            start_collect = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (collect_done) begin
      load_out  = 1'b1;
      res_entry = collect_q[0];
      if (min_remove) begin
        count_next = count - 1'b1;
      end
    end
  end

  // control: count, collect wait and state
  always_comb begin
    state_next = state;
    if (start_collect) begin
      state_next = S_COLLECT;
    end else if (collect_done) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      wait_cnt   <= '0;
      min_remove <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (start_collect) begin
        wait_cnt   <= '0;
        min_remove <= (op == OP_REMOVE_MIN);
      end else if (state == S_COLLECT && wait_cnt != WAIT_W'(CAPACITY - 1)) begin
        wait_cnt <= wait_cnt + 1'b1;
      end
    end
  end

  // output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status  <= res_status;
      out_key     <= res_entry.key;
      out_payload <= res_entry.payload;
      out_count   <= count_next;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {{OUT_PAD_W{1'b0}}, CNT_OUT_W'(out_count), out_payload, out_key};

  // chain of cells, slot 0 holds the maximum
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    dpq_entry_t left_e;
    dpq_entry_t right_e;
    dpq_entry_t coll_in;
    logic       left_gt;

    if (i == 0) begin : g_first
      assign left_e  = '0;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left_e  = cell_q[i-1];
      assign left_gt = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e = cell_q[i];
      assign coll_in = '0;
    end else begin : g_inner
      assign right_e = cell_q[i+1];
      assign coll_in = collect_q[i+1];
    end

    dpq_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .count       (count),
      .left        (left_e),
      .left_gt     (left_gt),
      .right       (right_e),
      .collect_in  (coll_in),
      .cur         (cell_q[i]),
      .gt          (cell_gt[i]),
      .collect_out (collect_q[i])
    );
  end

  // the queue never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // the two head slots stay in descending key order
  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    count >= CNT_W'(2) |-> $signed(cell_q[0].key) >= $signed(cell_q[1].key))
    else $error("head slots out of order");

  // an insert into a full queue reports full and leaves the count alone
  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    s_fire && op == OP_INSERT && full
    |=> m_tvalid && m_tuser == STAT_FULL && count == $past(count))
    else $error("full insert mishandled");

  // a successful remove max drops exactly one entry
  a_remove_max: assert property (@(posedge clk) disable iff (rst)
    s_fire && op == OP_REMOVE_MAX && !empty |=> count == $past(count) - 1'b1)
    else $error("remove max count wrong");

  // no request is taken while the tail readout is in progress
  a_collect_block: assert property (@(posedge clk) disable iff (rst)
    start_collect |=> !s_tready)
    else $error("request accepted during tail readout");

endmodule

`default_nettype wire

// File: rtl/dpq_cell.sv
// One slot of the sorted chain: holds an entry, compares against the
// broadcast key, and passes entries and the tail readout to its neighbors.
// Depends on dpq_pkg.
`default_nettype none

module dpq_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  wire                        clk,
  input  wire dpq_pkg::dpq_cmd_t     cmd,
  input  wire  [CNT_W-1:0]           count,
  input  wire dpq_pkg::dpq_entry_t   left,
  input  wire                        left_gt,
  input  wire dpq_pkg::dpq_entry_t   right,
  input  wire dpq_pkg::dpq_entry_t   collect_in,
  output dpq_pkg::dpq_entry_t        cur,
  output logic                       gt,
  output dpq_pkg::dpq_entry_t        collect_out
);
  import dpq_pkg::*;

  logic occupied;
  logic is_last;

  assign occupied = count > CNT_W'(INDEX);
  assign is_last  = count == CNT_W'(INDEX + 1);

  // stored key ranks strictly above the new one: this slot stays put
  assign gt = occupied && ($signed(cur.key) > $signed(cmd.entry.key));

  // update slot: hold above the insert point, load at it, take left below it
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (!gt) begin
        if (INDEX == 0 || left_gt) begin
          cur <= cmd.entry;
        end else begin
          cur <= left;
        end
      end
    end else if (cmd.shift) begin
      cur <= right;
    end
  end

  // pass the tail entry down toward slot 0, one slot a cycle
  always_ff @(posedge clk) begin
    collect_out <= is_last ? cur : collect_in;
  end

endmodule

`default_nettype wire
